@@ hw/rtl/signed_byte_alu_mul_div_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the signed ALU
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef SIGNED_BYTE_ALU_MUL_DIV_ASSERT_SVH
`define SIGNED_BYTE_ALU_MUL_DIV_ASSERT_SVH
`ifndef SYNTHESIS
// assertion checked only out of reset
`define SBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// assertion also checked during reset
`define SBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBA_ASSERT(lbl, clk, rstn, prop, msg)
`define SBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hw/rtl/sba_pkg.sv @@
// ----------------------------------------------------------------------------
// sba_pkg
// Operation codes and the control word carried along the pipeline.
// ----------------------------------------------------------------------------
package sba_pkg;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0,
    OP_SUB = 5'd1,
    OP_MUL = 5'd2,
    OP_DIV = 5'd3,
    OP_REM = 5'd4,
    OP_AND = 5'd5,
    OP_OR  = 5'd6,
    OP_XOR = 5'd7,
    OP_NOT = 5'd8,
    OP_SHL = 5'd9,
    OP_SHR = 5'd10,
    OP_EQ  = 5'd11,
    OP_NE  = 5'd12,
    OP_LT  = 5'd13,
    OP_GT  = 5'd14,
    OP_GE  = 5'd15,
    OP_LE  = 5'd16,
    OP_ABS = 5'd17
  } op_e;

  typedef struct packed {
    op_e  op;
    logic err;
    logic cmp;
    logic q_neg;  // quotient is negated at the end
  } ctrl_t;

endpackage

@@ hw/rtl/signed_byte_alu_mul_div.sv @@
// ----------------------------------------------------------------------------
// signed_byte_alu_mul_div
// Signed two's complement ALU with multiply and divide on a row of cells.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  in      | in_valid_i, in_ready_o, operation_i,     | to block
//          | operand_a_i, operand_b_i                 |
//  out     | out_valid_o, out_ready_i, result_value_o,| from block
//          | compare_true_o, error_flag_o             |
//
//  One transaction per cycle while the output side keeps taking results.
//  The cell row does multiply and divide: one multiply bit and one quotient bit per cell,
//  DATA_WIDTH cells between the decode stage and the result register.
//  Reset clears the valid bit of every stage; payload registers are not reset.
//  Back pressure moves up stage by stage, so empty stages keep filling while
//  a finished result waits at the output.
// ----------------------------------------------------------------------------
`include "signed_byte_alu_mul_div_assert.svh"

module signed_byte_alu_mul_div #(
  parameter int DATA_WIDTH = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [4:0]                   operation_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] result_value_o,
  output logic                         compare_true_o,
  output logic                         error_flag_o
);

  localparam int W = DATA_WIDTH;

  logic [W:0]     vld;
  logic [W:0]     rdy;
  sba_pkg::ctrl_t ctrl   [W+1];
  logic [W-1:0]   res    [W+1];
  logic [W-1:0]   mcand  [W+1];
  logic [W-1:0]   mplier [W+1];
  logic [W-1:0]   prod   [W+1];
  logic [W-1:0]   rem    [W+1];
  logic [W-1:0]   dvd    [W+1];
  logic [W-1:0]   dvs    [W+1];
  logic [W-1:0]   result_u;

  sba_front #(.W(W)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .operation_i (operation_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .valid_o     (vld[0]),
    .ready_i     (rdy[0]),
    .ctrl_o      (ctrl[0]),
    .res_o       (res[0]),
    .mcand_o     (mcand[0]),
    .mplier_o    (mplier[0]),
    .dvd_o       (dvd[0]),
    .dvs_o       (dvs[0])
  );

  // accumulators start empty at the head of the row
  assign prod[0] = '0;
  assign rem[0]  = '0;

  for (genvar i = 0; i < W; i++) begin : g_cell
    sba_cell #(.W(W)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (vld[i]),
      .ready_o  (rdy[i]),
      .ctrl_i   (ctrl[i]),
      .res_i    (res[i]),
      .mcand_i  (mcand[i]),
      .mplier_i (mplier[i]),
      .prod_i   (prod[i]),
      .rem_i    (rem[i]),
      .dvd_i    (dvd[i]),
      .dvs_i    (dvs[i]),
      .valid_o  (vld[i+1]),
      .ready_i  (rdy[i+1]),
      .ctrl_o   (ctrl[i+1]),
      .res_o    (res[i+1]),
      .mcand_o  (mcand[i+1]),
      .mplier_o (mplier[i+1]),
      .prod_o   (prod[i+1]),
      .rem_o    (rem[i+1]),
      .dvd_o    (dvd[i+1]),
      .dvs_o    (dvs[i+1])
    );
  end

  sba_back #(.W(W)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (vld[W]),
    .ready_o        (rdy[W]),
    .ctrl_i         (ctrl[W]),
    .res_i          (res[W]),
    .prod_i         (prod[W]),
    .rem_i          (rem[W]),
    .dvd_i          (dvd[W]),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_u),
    .compare_true_o (compare_true_o),
    .error_flag_o   (error_flag_o)
  );

  assign result_value_o = result_u;

  `SBA_ASSERT(a_err_zero, clk_i, rst_ni, out_valid_o && error_flag_o |-> result_u == '0, "error result not zero")
  `SBA_ASSERT(a_cmp_zero, clk_i, rst_ni, out_valid_o && compare_true_o |-> result_u == '0 && !error_flag_o, "compare result not clean")
  `SBA_ASSERT(a_load, clk_i, rst_ni, in_valid_i && in_ready_o |=> vld[0], "accepted transaction not in decode stage")
  `SBA_ASSERT_ALWAYS(a_empty_ready, clk_i, vld == '0 |-> in_ready_o, "empty pipeline refuses input")

endmodule

@@ hw/rtl/sba_front.sv @@
// ----------------------------------------------------------------------------
// sba_front
// Decode stage: operations other than multiply and divide, operand magnitudes, error checks.
// ----------------------------------------------------------------------------
module sba_front #(
  parameter int W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [4:0]          operation_i,
  input  logic signed [W-1:0] operand_a_i,
  input  logic signed [W-1:0] operand_b_i,
  output logic                valid_o,
  input  logic                ready_i,
  output sba_pkg::ctrl_t      ctrl_o,
  output logic [W-1:0]        res_o,
  output logic [W-1:0]        mcand_o,
  output logic [W-1:0]        mplier_o,
  output logic [W-1:0]        dvd_o,
  output logic [W-1:0]        dvs_o
);

  localparam logic [W-1:0] WIDTH_VAL = W'(W);

  logic           valid_q;
  sba_pkg::ctrl_t ctrl_d, ctrl_q;
  logic [W-1:0]   res_d, res_q;
  logic [W-1:0]   a_u, b_u, a_mag, b_mag;
  logic [W-1:0]   mcand_q, mplier_q, dvd_q, dvs_q;
  logic           shift_bad, div_zero, a_lt_b;

  assign a_u       = operand_a_i;
  assign b_u       = operand_b_i;
  assign a_mag     = operand_a_i[W-1] ? ({W{1'b0}} - a_u) : a_u;
  assign b_mag     = operand_b_i[W-1] ? ({W{1'b0}} - b_u) : b_u;
  assign shift_bad = operand_b_i[W-1] || (b_u > WIDTH_VAL);
  assign div_zero  = (b_u == '0);
  assign a_lt_b    = (operand_a_i < operand_b_i);

  always_comb begin
    ctrl_d.op    = sba_pkg::op_e'(operation_i);
    ctrl_d.err   = 1'b0;
    ctrl_d.cmp   = 1'b0;
    ctrl_d.q_neg = operand_a_i[W-1] ^ operand_b_i[W-1];
    res_d        = '0;
    case (ctrl_d.op)
      sba_pkg::OP_ADD: res_d = a_u + b_u;
      sba_pkg::OP_SUB: res_d = a_u - b_u;
      sba_pkg::OP_MUL: res_d = '0;
      sba_pkg::OP_DIV, sba_pkg::OP_REM: ctrl_d.err = div_zero;
      sba_pkg::OP_AND: res_d = a_u & b_u;
      sba_pkg::OP_OR:  res_d = a_u | b_u;
      sba_pkg::OP_XOR: res_d = a_u ^ b_u;
      sba_pkg::OP_NOT: res_d = ~a_u;
      // a shift by W or more clears the word; above W or negative it also flags an error
      sba_pkg::OP_SHL: begin
        ctrl_d.err = shift_bad;
        res_d      = shift_bad ? '0 : (a_u << b_u);
      end
      sba_pkg::OP_SHR: begin
        ctrl_d.err = shift_bad;
        res_d      = shift_bad ? '0 : (a_u >> b_u);
      end
      sba_pkg::OP_EQ:  ctrl_d.cmp = (a_u == b_u);
      sba_pkg::OP_NE:  ctrl_d.cmp = (a_u != b_u);
      sba_pkg::OP_LT:  ctrl_d.cmp = a_lt_b;
      sba_pkg::OP_GT:  ctrl_d.cmp = !a_lt_b && (a_u != b_u);
      sba_pkg::OP_GE:  ctrl_d.cmp = !a_lt_b;
      sba_pkg::OP_LE:  ctrl_d.cmp = a_lt_b || (a_u == b_u);
      sba_pkg::OP_ABS: res_d = a_mag;
      default:         res_d = '0;
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q   <= ctrl_d;
      res_q    <= res_d;
      mcand_q  <= a_u;
      mplier_q <= b_u;
      dvd_q    <= a_mag;
      dvs_q    <= b_mag;
    end
  end

  assign valid_o  = valid_q;
  assign ctrl_o   = ctrl_q;
  assign res_o    = res_q;
  assign mcand_o  = mcand_q;
  assign mplier_o = mplier_q;
  assign dvd_o    = dvd_q;
  assign dvs_o    = dvs_q;

endmodule

@@ hw/rtl/sba_cell.sv @@
// ----------------------------------------------------------------------------
// sba_cell
// One pipeline cell: one shift-add multiply step and one restoring divide step.
// ----------------------------------------------------------------------------
module sba_cell #(
  parameter int W = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  sba_pkg::ctrl_t ctrl_i,
  input  logic [W-1:0]   res_i,
  input  logic [W-1:0]   mcand_i,
  input  logic [W-1:0]   mplier_i,
  input  logic [W-1:0]   prod_i,
  input  logic [W-1:0]   rem_i,
  input  logic [W-1:0]   dvd_i,
  input  logic [W-1:0]   dvs_i,
  output logic           valid_o,
  input  logic           ready_i,
  output sba_pkg::ctrl_t ctrl_o,
  output logic [W-1:0]   res_o,
  output logic [W-1:0]   mcand_o,
  output logic [W-1:0]   mplier_o,
  output logic [W-1:0]   prod_o,
  output logic [W-1:0]   rem_o,
  output logic [W-1:0]   dvd_o,
  output logic [W-1:0]   dvs_o
);

  logic           valid_q;
  sba_pkg::ctrl_t ctrl_q;
  logic [W-1:0]   res_q, dvs_q;
  logic [W-1:0]   mcand_d, mcand_q, mplier_d, mplier_q, prod_d, prod_q;
  logic [W-1:0]   rem_sh, rem_d, rem_q, dvd_d, dvd_q;
  logic           fits;

  // partial remainder stays below the divisor, so its top bit is free
  assign rem_sh   = {rem_i[W-2:0], dvd_i[W-1]};
  assign fits     = (rem_sh >= dvs_i);
  assign rem_d    = fits ? (rem_sh - dvs_i) : rem_sh;
  assign dvd_d    = {dvd_i[W-2:0], fits};  // quotient bits enter from the bottom

  assign prod_d   = mplier_i[0] ? (prod_i + mcand_i) : prod_i;
  assign mcand_d  = {mcand_i[W-2:0], 1'b0};
  assign mplier_d = {1'b0, mplier_i[W-1:1]};

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      ctrl_q   <= ctrl_i;
      res_q    <= res_i;
      mcand_q  <= mcand_d;
      mplier_q <= mplier_d;
      prod_q   <= prod_d;
      rem_q    <= rem_d;
      dvd_q    <= dvd_d;
      dvs_q    <= dvs_i;
    end
  end

  assign valid_o  = valid_q;
  assign ctrl_o   = ctrl_q;
  assign res_o    = res_q;
  assign mcand_o  = mcand_q;
  assign mplier_o = mplier_q;
  assign prod_o   = prod_q;
  assign rem_o    = rem_q;
  assign dvd_o    = dvd_q;
  assign dvs_o    = dvs_q;

endmodule

@@ hw/rtl/sba_back.sv @@
// ----------------------------------------------------------------------------
// sba_back
// Result stage: quotient sign fix, result select and the output register.
// ----------------------------------------------------------------------------
module sba_back #(
  parameter int W = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  sba_pkg::ctrl_t ctrl_i,
  input  logic [W-1:0]   res_i,
  input  logic [W-1:0]   prod_i,
  input  logic [W-1:0]   rem_i,
  input  logic [W-1:0]   dvd_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [W-1:0]   result_value_o,
  output logic           compare_true_o,
  output logic           error_flag_o
);

  logic         valid_q, cmp_q, err_q;
  logic [W-1:0] quo, res_d, res_q;

  assign quo = ctrl_i.q_neg ? ({W{1'b0}} - dvd_i) : dvd_i;

  always_comb begin
    case (ctrl_i.op)
      sba_pkg::OP_MUL: res_d = prod_i;
      sba_pkg::OP_DIV: res_d = ctrl_i.err ? '0 : quo;
      sba_pkg::OP_REM: res_d = ctrl_i.err ? '0 : rem_i;
      default:         res_d = res_i;
    endcase
  end

  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
      cmp_q <= ctrl_i.cmp;
      err_q <= ctrl_i.err;
    end
  end

  assign out_valid_o    = valid_q;
  assign result_value_o = res_q;
  assign compare_true_o = cmp_q;
  assign error_flag_o   = err_q;

endmodule

@@ verif/tb_signed_byte_alu_mul_div.sv @@
// ----------------------------------------------------------------------------
// tb_signed_byte_alu_mul_div
// Self-checking bench for the signed byte ALU. Every accepted input transaction
// is run through a local predictor, and each output transaction is checked
// in order against the oldest predicted result. The stimulus is a directed
// set of corner cases, then random traffic under several idle mixes, then a
// long output stall that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_signed_byte_alu_mul_div;

  localparam int DATA_WIDTH = 8;
  localparam int LATENCY    = DATA_WIDTH + 2;
  localparam int MAX_PRINTS = 40;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  cmp;
    logic  err;
  } alu_result_t;

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [4:0]  operation_i    = sba_pkg::OP_ADD;
  word_t       operand_a_i    = '0;
  word_t       operand_b_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  word_t       result_value_o;
  logic        compare_true_o;
  logic        error_flag_o;

  alu_result_t pending_results[$];
  int          mismatch_count = 0;
  int          tx_idle_pct    = 0;
  int          rx_idle_pct    = 0;
  int          rx_hold_len    = 0;

  signed_byte_alu_mul_div #(
    .DATA_WIDTH(DATA_WIDTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_value_o(result_value_o),
    .compare_true_o(compare_true_o),
    .error_flag_o  (error_flag_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic alu_result_t alu_predict(logic [4:0] op, word_t a, word_t b);
    alu_result_t r;
    logic [DATA_WIDTH-1:0] mag_a;
    logic [DATA_WIDTH-1:0] mag_b;
    logic [DATA_WIDTH-1:0] quo;
    r     = '0;
    // most negative value maps to its own pattern, read as unsigned 2^(N-1)
    mag_a = a[DATA_WIDTH-1] ? -a : a;
    mag_b = b[DATA_WIDTH-1] ? -b : b;
    case (op)
      sba_pkg::OP_ADD: r.value = a + b;
      sba_pkg::OP_SUB: r.value = a - b;
      sba_pkg::OP_MUL: r.value = a * b;
      sba_pkg::OP_DIV, sba_pkg::OP_REM: begin
        if (b == 0) begin
          r.err = 1'b1;
        end else if (op == sba_pkg::OP_DIV) begin
          quo     = mag_a / mag_b;
          r.value = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -quo : quo;
        end else begin
          r.value = mag_a % mag_b;
        end
      end
      sba_pkg::OP_AND: r.value = a & b;
      sba_pkg::OP_OR:  r.value = a | b;
      sba_pkg::OP_XOR: r.value = a ^ b;
      sba_pkg::OP_NOT: r.value = ~a;
      sba_pkg::OP_SHL, sba_pkg::OP_SHR: begin
        if (b[DATA_WIDTH-1] || b > DATA_WIDTH) begin
          r.err = 1'b1;
        end else if (b == DATA_WIDTH) begin
          r.value = '0;
        end else if (op == sba_pkg::OP_SHL) begin
          r.value = a << b;
        end else begin
          r.value = $unsigned(a) >> b;
        end
      end
      sba_pkg::OP_EQ:  r.cmp = (a == b);
      sba_pkg::OP_NE:  r.cmp = (a != b);
      sba_pkg::OP_LT:  r.cmp = (a < b);
      sba_pkg::OP_GT:  r.cmp = (a > b);
      sba_pkg::OP_GE:  r.cmp = (a >= b);
      sba_pkg::OP_LE:  r.cmp = (a <= b);
      sba_pkg::OP_ABS: r.value = mag_a;
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // output side: random ready, optional long hold, in-order check
  initial begin
    alu_result_t want;
    int          hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction value=%0d", result_value_o));
        end else begin
          want = pending_results.pop_front();
          if (result_value_o !== want.value)
            report_mismatch($sformatf("result_value got %0d want %0d",
                                      result_value_o, want.value));
          if (compare_true_o !== want.cmp)
            report_mismatch($sformatf("compare_true got %b want %b",
                                      compare_true_o, want.cmp));
          if (error_flag_o !== want.err)
            report_mismatch($sformatf("error_flag got %b want %b",
                                      error_flag_o, want.err));
        end
      end
      if (rx_hold_len != 0) begin
        hold_left   = rx_hold_len;
        rx_hold_len = 0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // valid is left high after acceptance; the next call lowers it or reloads it
  task automatic send_op(logic [4:0] op, word_t a, word_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(alu_predict(op, a, b));
  endtask

  function automatic word_t pick_operand();
    case ($urandom_range(9))
      0:       return word_t'(-128);
      1:       return word_t'(127);
      2:       return word_t'(0);
      3:       return word_t'(-1);
      default: return word_t'($urandom);
    endcase
  endfunction

  task automatic test_corner_cases();
    send_op(sba_pkg::OP_ADD, 127, 1);
    send_op(sba_pkg::OP_SUB, -128, 1);
    send_op(sba_pkg::OP_MUL, 127, 127);
    send_op(sba_pkg::OP_MUL, -128, -1);
    send_op(sba_pkg::OP_DIV, 100, 0);
    send_op(sba_pkg::OP_REM, -5, 0);
    send_op(sba_pkg::OP_DIV, -128, -1);
    send_op(sba_pkg::OP_DIV, -7, 2);
    send_op(sba_pkg::OP_REM, -7, 2);
    send_op(sba_pkg::OP_REM, 7, -2);
    send_op(sba_pkg::OP_AND, -86, 85);
    send_op(sba_pkg::OP_OR, -86, 85);
    send_op(sba_pkg::OP_XOR, -1, 85);
    send_op(sba_pkg::OP_NOT, -128, 0);
    send_op(sba_pkg::OP_SHL, 1, 7);
    send_op(sba_pkg::OP_SHL, -1, 8);
    send_op(sba_pkg::OP_SHR, -128, 9);
    send_op(sba_pkg::OP_SHR, -128, -1);
    send_op(sba_pkg::OP_SHR, -128, 1);
    send_op(sba_pkg::OP_EQ, -128, -128);
    send_op(sba_pkg::OP_NE, 127, -128);
    send_op(sba_pkg::OP_LT, -128, 127);
    send_op(sba_pkg::OP_GT, -128, 127);
    send_op(sba_pkg::OP_GE, 5, 5);
    send_op(sba_pkg::OP_LE, 127, -128);
    send_op(sba_pkg::OP_ABS, -128, 0);
    send_op(5'd31, -1, -1);
    send_op(sba_pkg::OP_ABS + 5'd1, 3, 4);
  endtask

  task automatic test_random_traffic(int count, int tx_pct, int rx_pct);
    logic [4:0] op;
    word_t      a;
    word_t      b;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      if ($urandom_range(19) == 0) op = 5'($urandom_range(31, int'(sba_pkg::OP_ABS) + 1));
      else                         op = 5'($urandom_range(int'(sba_pkg::OP_ABS)));
      a = pick_operand();
      b = pick_operand();
      // keep most shift amounts legal, with the edges just outside
      if ((op == sba_pkg::OP_SHL || op == sba_pkg::OP_SHR) && $urandom_range(9) < 7)
        b = word_t'($urandom_range(DATA_WIDTH));
      else if ((op == sba_pkg::OP_SHL || op == sba_pkg::OP_SHR) && $urandom_range(1) == 0)
        b = ($urandom_range(1) == 0) ? word_t'(-1) : word_t'(DATA_WIDTH + 1);
      if ((op == sba_pkg::OP_DIV || op == sba_pkg::OP_REM) && $urandom_range(9) == 0)
        b = '0;
      send_op(op, a, b);
    end
  endtask

  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_len = 80;
    repeat (40)
      send_op(5'($urandom_range(int'(sba_pkg::OP_ABS))), pick_operand(), pick_operand());
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_cases();
    test_random_traffic(361, 34, 61);
    test_random_traffic(361, 61, 34);
    test_random_traffic(361, 0, 0);
    test_output_stall();

    in_valid_i  <= 1'b0;
    rx_idle_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (2 * LATENCY) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sba_pkg.sv
hw/rtl/sba_front.sv
hw/rtl/sba_cell.sv
hw/rtl/sba_back.sv
hw/rtl/signed_byte_alu_mul_div.sv
verif/tb_signed_byte_alu_mul_div.sv
